@@ rtl/plm_pkg.sv @@
`default_nettype none

package plm_pkg;

  // Per-cell move selected by the sequencer each cycle
  typedef enum logic [1:0] {
    OP_HOLD  = 2'd0,  // keep the stored entry
    OP_PREV  = 2'd1,  // take the entry of the cell below (shift up)
    OP_NEXT  = 2'd2,  // take the entry of the cell above (shift down)
    OP_BCAST = 2'd3   // take the broadcast word
  } plm_op_e;

endpackage

`default_nettype wire

@@ rtl/plm_cell.sv @@
`default_nettype none

module plm_cell
  import plm_pkg::*;
#(
  parameter int VALUE_WIDTH = 32
) (
  input  wire logic                   clk_i,
  input  wire plm_op_e                op_i,
  input  wire logic [VALUE_WIDTH-1:0] prev_i,
  input  wire logic [VALUE_WIDTH-1:0] next_i,
  input  wire logic [VALUE_WIDTH-1:0] bcast_i,
  output logic      [VALUE_WIDTH-1:0] entry_o
);

  logic [VALUE_WIDTH-1:0] entry_q;
  logic [VALUE_WIDTH-1:0] entry_d;

  // Select the new entry from the neighbors or the broadcast word
  always_comb begin
    case (op_i)
      OP_HOLD:  entry_d = entry_q;
      OP_PREV:  entry_d = prev_i;
      OP_NEXT:  entry_d = next_i;
      OP_BCAST: entry_d = bcast_i;
      default:  entry_d = entry_q;
    endcase
  end

  // Payload register, no reset needed
  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

  assign entry_o = entry_q;

endmodule

`default_nettype wire

@@ rtl/plm_ctrl.sv @@
`default_nettype none

module plm_ctrl
  import plm_pkg::*;
#(
  parameter int CAPACITY    = 16,
  parameter int VALUE_WIDTH = 32
) (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   in_valid_i,
  output logic                        in_ready_o,
  input  wire logic [2:0]             req_type_i,
  input  wire logic signed [31:0]     value_i,
  input  wire logic [4:0]             position_i,
  input  wire logic [4:0]             other_position_i,
  output logic                        out_valid_o,
  input  wire logic                   out_ready_i,
  output logic [1:0]                  status_o,
  output logic signed [31:0]          entry_value_o,
  output logic [3:0]                  entry_index_o,
  output logic [4:0]                  entry_count_o,
  output logic                        last_o,
  input  wire logic [VALUE_WIDTH-1:0] head_i,
  output plm_op_e                     cell_op_o [CAPACITY],
  output logic [VALUE_WIDTH-1:0]      bcast_o
);

  localparam int CW = $clog2(CAPACITY + 1);
  localparam int IW = $clog2(CAPACITY);
  localparam int PW = (CW > 5) ? CW : 5;

  localparam logic [2:0] REQ_INS_FRONT = 3'd0;
  localparam logic [2:0] REQ_INS_BACK  = 3'd1;
  localparam logic [2:0] REQ_INS_POS   = 3'd2;
  localparam logic [2:0] REQ_DEL_FRONT = 3'd3;
  localparam logic [2:0] REQ_DEL_BACK  = 3'd4;
  localparam logic [2:0] REQ_DEL_POS   = 3'd5;
  localparam logic [2:0] REQ_SWAP      = 3'd6;
  localparam logic [2:0] REQ_DUMP      = 3'd7;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_EMPTY = 2'd1;
  localparam logic [1:0] ST_RANGE = 2'd2;
  localparam logic [1:0] ST_FULL  = 2'd3;

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_DUMP  = 2'd1;
  localparam logic [1:0] S_SW_RD = 2'd2;
  localparam logic [1:0] S_SW_WR = 2'd3;

  logic [1:0]             state_q, state_d;
  logic [CW-1:0]          count_q, count_d;
  logic [IW-1:0]          step_q, step_d;
  logic [IW-1:0]          pa_q, pa_d;
  logic [IW-1:0]          pb_q, pb_d;
  logic [VALUE_WIDTH-1:0] va_q, va_d;
  logic [VALUE_WIDTH-1:0] vb_q, vb_d;

  logic                   out_valid_q, out_valid_d;
  logic [1:0]             status_q, status_d;
  logic [31:0]            val_q, val_d;
  logic [3:0]             idx_q, idx_d;
  logic [4:0]             cnt_q, cnt_d;
  logic                   last_q, last_d;

  logic                   out_free;
  logic                   in_fire;
  logic [PW-1:0]          pe, qe, ce;
  logic [PW-1:0]          ins_p, del_p, op_p;
  logic                   full, empty, last_step;
  logic [CW-1:0]          cnt_m1;
  logic [63:0]            v_ext;
  logic                   do_ins, do_del, do_rot;

  // Handshake and decode helpers
  assign out_free   = !out_valid_q || out_ready_i;
  assign in_ready_o = (state_q == S_IDLE) && out_free;
  assign in_fire    = in_valid_i && in_ready_o;

  assign pe        = PW'(position_i);
  assign qe        = PW'(other_position_i);
  assign ce        = PW'(count_q);
  assign full      = (count_q == CW'(CAPACITY));
  assign empty     = (count_q == '0);
  assign cnt_m1    = count_q - CW'(1);
  assign last_step = (CW'(step_q) == cnt_m1);
  assign v_ext     = {{32{value_i[31]}}, value_i};

  // Resolve the target position of inserts and deletes
  always_comb begin
    case (req_type_i)
      REQ_INS_FRONT: ins_p = '0;
      REQ_INS_BACK:  ins_p = ce;
      default:       ins_p = pe;
    endcase
    case (req_type_i)
      REQ_DEL_FRONT: del_p = '0;
      REQ_DEL_BACK:  del_p = PW'(cnt_m1);
      default:       del_p = pe;
    endcase
  end

  // Sequencer: shifts for inserts and deletes, rotation passes for dump and swap
  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    step_d      = step_q;
    pa_d        = pa_q;
    pb_d        = pb_q;
    va_d        = va_q;
    vb_d        = vb_q;
    out_valid_d = out_valid_q && !out_ready_i;
    status_d    = status_q;
    val_d       = val_q;
    idx_d       = idx_q;
    cnt_d       = cnt_q;
    last_d      = last_q;
    do_ins      = 1'b0;
    do_del      = 1'b0;
    do_rot      = 1'b0;
    op_p        = '0;
    bcast_o     = head_i;

    case (state_q)
      S_IDLE: begin
        if (in_fire) begin
          out_valid_d = 1'b1;
          status_d    = ST_OK;
          val_d       = '0;
          idx_d       = '0;
          last_d      = 1'b1;
          case (req_type_i)
            REQ_INS_FRONT, REQ_INS_BACK, REQ_INS_POS: begin
              if (ins_p > ce) begin
                status_d = ST_RANGE;
              end else if (full) begin
                status_d = ST_FULL;
              end else begin
                do_ins  = 1'b1;
                op_p    = ins_p;
                bcast_o = v_ext[VALUE_WIDTH-1:0];
                count_d = count_q + CW'(1);
              end
            end
            REQ_DEL_FRONT, REQ_DEL_BACK, REQ_DEL_POS: begin
              if (empty) begin
                status_d = ST_EMPTY;
              end else if (del_p >= ce) begin
                status_d = ST_RANGE;
              end else begin
                do_del  = 1'b1;
                op_p    = del_p;
                count_d = cnt_m1;
              end
            end
            REQ_SWAP: begin
              if (pe == qe) begin
                status_d = ST_OK;
              end else if (pe >= ce || qe >= ce) begin
                status_d = ST_RANGE;
              end else begin
                out_valid_d = 1'b0;
                pa_d        = IW'(pe);
                pb_d        = IW'(qe);
                step_d      = '0;
                state_d     = S_SW_RD;
              end
            end
            REQ_DUMP: begin
              if (empty) begin
                status_d = ST_EMPTY;
              end else begin
                out_valid_d = 1'b0;
                step_d      = '0;
                state_d     = S_DUMP;
              end
            end
            default: ;
          endcase
          cnt_d = 5'(count_d);
        end
      end

      S_DUMP: begin
        // Emit the head entry and rotate it to the tail
        if (out_free) begin
          out_valid_d = 1'b1;
          status_d    = ST_OK;
          val_d       = 32'(head_i);
          idx_d       = 4'(step_q);
          cnt_d       = 5'(count_q);
          last_d      = last_step;
          do_rot      = 1'b1;
          step_d      = step_q + IW'(1);
          if (last_step) begin
            state_d = S_IDLE;
          end
        end
      end

      S_SW_RD: begin
        // Capture both entries during one full rotation
        do_rot = 1'b1;
        if (step_q == pa_q) va_d = head_i;
        if (step_q == pb_q) vb_d = head_i;
        step_d = step_q + IW'(1);
        if (last_step) begin
          step_d  = '0;
          state_d = S_SW_WR;
        end
      end

      S_SW_WR: begin
        // Rotate again, substituting the exchanged entries
        do_rot = 1'b1;
        if (step_q == pa_q) begin
          bcast_o = vb_q;
        end else if (step_q == pb_q) begin
          bcast_o = va_q;
        end
        step_d = step_q + IW'(1);
        if (last_step) begin
          state_d     = S_IDLE;
          out_valid_d = 1'b1;
          status_d    = ST_OK;
          val_d       = '0;
          idx_d       = '0;
          cnt_d       = 5'(count_q);
          last_d      = 1'b1;
        end
      end

      default: state_d = S_IDLE;
    endcase
  end

  // Per-cell moves for shift up, shift down and rotation
  always_comb begin
    for (int i = 0; i < CAPACITY; i++) begin
      cell_op_o[i] = OP_HOLD;
      if (do_ins) begin
        if (PW'(i) > op_p) begin
          cell_op_o[i] = OP_PREV;
        end else if (PW'(i) == op_p) begin
          cell_op_o[i] = OP_BCAST;
        end
      end else if (do_del) begin
        if (PW'(i) >= op_p) begin
          cell_op_o[i] = OP_NEXT;
        end
      end else if (do_rot) begin
        if (CW'(i) < cnt_m1) begin
          cell_op_o[i] = OP_NEXT;
        end else if (CW'(i) == cnt_m1) begin
          cell_op_o[i] = OP_BCAST;
        end
      end
    end
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      step_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      step_q      <= step_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    pa_q     <= pa_d;
    pb_q     <= pb_d;
    va_q     <= va_d;
    vb_q     <= vb_d;
    status_q <= status_d;
    val_q    <= val_d;
    idx_q    <= idx_d;
    cnt_q    <= cnt_d;
    last_q   <= last_d;
  end

  assign out_valid_o   = out_valid_q;
  assign status_o      = status_q;
  assign entry_value_o = val_q;
  assign entry_index_o = idx_q;
  assign entry_count_o = cnt_q;
  assign last_o        = last_q;

  // Checks
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    CW'(CAPACITY) >= count_q)
    else $error("list count exceeds capacity");

  a_count_on_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_fire |=> $stable(count_q))
    else $error("list count changed without an accepted item");

  a_busy_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != S_IDLE) |-> (count_q != '0))
    else $error("rotation pass running on an empty list");

  a_swap_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SW_RD) |=> (state_q == S_SW_RD || state_q == S_SW_WR))
    else $error("swap read pass left without write pass");

endmodule

`default_nettype wire

@@ rtl/positional_list_engine.sv @@
`default_nettype none

// Bounded ordered list of CAPACITY signed entries held in a chain of cells,
// one entry per cell, with a live count that resets to zero (entries are
// not cleared and need no clearing pass). Inserts and deletes (front, back
// or at a position) shift the cells and return one result item.
// Every entry leaves the chain through the head cell: a dump rotates the
// list once and returns one item per entry, one per cycle while the output
// side keeps up; a swap of two distinct positions takes two full rotations
// before its single result item. Errors return one item and
// leave the list unchanged. Only one request is worked on at a time; a new
// item is taken once the output register is empty or is being read in the
// same cycle.
module positional_list_engine
  import plm_pkg::*;
#(
  parameter int CAPACITY    = 16,
  parameter int VALUE_WIDTH = 32
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_ready_o,
  input  wire logic [2:0]         req_type_i,
  input  wire logic signed [31:0] value_i,
  input  wire logic [4:0]         position_i,
  input  wire logic [4:0]         other_position_i,
  output logic                    out_valid_o,
  input  wire logic               out_ready_i,
  output logic [1:0]              status_o,
  output logic signed [31:0]      entry_value_o,
  output logic [3:0]              entry_index_o,
  output logic [4:0]              entry_count_o,
  output logic                    last_o
);

  plm_op_e                cell_op [CAPACITY];
  logic [VALUE_WIDTH-1:0] entry   [CAPACITY];
  logic [VALUE_WIDTH-1:0] bcast;

  // Sequencer and output register
  plm_ctrl #(
    .CAPACITY    (CAPACITY),
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_ctrl (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .req_type_i       (req_type_i),
    .value_i          (value_i),
    .position_i       (position_i),
    .other_position_i (other_position_i),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .status_o         (status_o),
    .entry_value_o    (entry_value_o),
    .entry_index_o    (entry_index_o),
    .entry_count_o    (entry_count_o),
    .last_o           (last_o),
    .head_i           (entry[0]),
    .cell_op_o        (cell_op),
    .bcast_o          (bcast)
  );

  // Chain of entry cells; the ends see the broadcast word
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic [VALUE_WIDTH-1:0] prev_w;
    logic [VALUE_WIDTH-1:0] next_w;

    if (i == 0) begin : g_first
      assign prev_w = bcast;
    end else begin : g_mid_lo
      assign prev_w = entry[i-1];
    end

    if (i == CAPACITY - 1) begin : g_last
      assign next_w = bcast;
    end else begin : g_mid_hi
      assign next_w = entry[i+1];
    end

    plm_cell #(
      .VALUE_WIDTH (VALUE_WIDTH)
    ) u_cell (
      .clk_i   (clk_i),
      .op_i    (cell_op[i]),
      .prev_i  (prev_w),
      .next_i  (next_w),
      .bcast_i (bcast),
      .entry_o (entry[i])
    );
  end

endmodule

`default_nettype wire

@@ tb/tb_top.sv @@
`default_nettype none

module tb_top;

  localparam int unsigned LIST_DEPTH = 16;
  localparam int unsigned RAND_PHASE_ITEMS = 16;
  localparam int unsigned SETTLE_CYCLES = 2 * LIST_DEPTH + 16;

  typedef enum logic [2:0] {
    REQ_INS_FRONT = 3'd0,
    REQ_INS_BACK  = 3'd1,
    REQ_INS_AT    = 3'd2,
    REQ_DEL_FRONT = 3'd3,
    REQ_DEL_BACK  = 3'd4,
    REQ_DEL_AT    = 3'd5,
    REQ_SWAP      = 3'd6,
    REQ_DUMP      = 3'd7
  } list_req_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_RANGE = 2'd2,
    ST_FULL  = 2'd3
  } list_status_e;

  typedef struct packed {
    list_req_e          kind;
    logic signed [31:0] value;
    logic [4:0]         pos;
    logic [4:0]         pos2;
  } list_req_t;

  typedef struct packed {
    list_status_e       status;
    logic signed [31:0] value;
    logic [3:0]         index;
    logic [4:0]         count;
    logic               last;
  } list_res_t;

  // One line of the directed table; fixed rows carry their own answer
  typedef struct packed {
    list_req_t    req;
    logic [4:0]   rep;
    logic         fixed;
    list_status_e status;
    logic [4:0]   count;
  } plan_row_t;

  logic               clk_i;
  logic               rst_ni;
  logic               in_valid_i;
  logic               in_ready_o;
  logic [2:0]         req_type_i;
  logic signed [31:0] value_i;
  logic [4:0]         position_i;
  logic [4:0]         other_position_i;
  logic               out_valid_o;
  logic               out_ready_i;
  logic [1:0]         status_o;
  logic signed [31:0] entry_value_o;
  logic [3:0]         entry_index_o;
  logic [4:0]         entry_count_o;
  logic               last_o;

  // Shadow copy of the list
  logic [31:0] shadow_list [LIST_DEPTH];
  int unsigned shadow_count;

  list_res_t   awaited_results [$];
  plan_row_t   plan_rows [$];

  int unsigned send_idle_pct;
  int unsigned recv_stall_pct;
  int unsigned mismatch_count;
  int unsigned items_sent;
  int unsigned results_checked;
  int unsigned deepest_count;

  positional_list_engine #(
    .CAPACITY   (LIST_DEPTH),
    .VALUE_WIDTH(32)
  ) dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .req_type_i      (req_type_i),
    .value_i         (value_i),
    .position_i      (position_i),
    .other_position_i(other_position_i),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .status_o        (status_o),
    .entry_value_o   (entry_value_o),
    .entry_index_o   (entry_index_o),
    .entry_count_o   (entry_count_o),
    .last_o          (last_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // Insert v at index p, shifting the tail up
  function automatic list_status_e shadow_insert(int unsigned p, logic [31:0] v);
    if (p > shadow_count) return ST_RANGE;
    if (shadow_count >= LIST_DEPTH) return ST_FULL;
    for (int unsigned i = shadow_count; i > p; i--) shadow_list[i] = shadow_list[i - 1];
    shadow_list[p] = v;
    shadow_count++;
    return ST_OK;
  endfunction

  // Remove index p, shifting the tail down
  function automatic list_status_e shadow_remove(int unsigned p);
    if (shadow_count == 0) return ST_EMPTY;
    if (p >= shadow_count) return ST_RANGE;
    for (int unsigned i = p; i + 1 < shadow_count; i++) shadow_list[i] = shadow_list[i + 1];
    shadow_count--;
    return ST_OK;
  endfunction

  // Apply one request to the shadow list and queue the items it returns
  task automatic predict_list_request(input list_req_t r, input bit queue_items);
    list_status_e st;
    list_res_t    res;
    logic [31:0]  held;
    st = ST_OK;
    res = '0;
    case (r.kind)
      REQ_INS_FRONT: st = shadow_insert(0, r.value);
      REQ_INS_BACK:  st = shadow_insert(shadow_count, r.value);
      REQ_INS_AT:    st = shadow_insert(r.pos, r.value);
      REQ_DEL_FRONT: st = shadow_remove(0);
      REQ_DEL_BACK:  st = (shadow_count == 0) ? ST_EMPTY : shadow_remove(shadow_count - 1);
      REQ_DEL_AT:    st = shadow_remove(r.pos);
      REQ_SWAP: begin
        if (r.pos == r.pos2) begin
          st = ST_OK;
        end else if (r.pos >= shadow_count || r.pos2 >= shadow_count) begin
          st = ST_RANGE;
        end else begin
          held = shadow_list[r.pos];
          shadow_list[r.pos] = shadow_list[r.pos2];
          shadow_list[r.pos2] = held;
        end
      end
      default: st = (shadow_count == 0) ? ST_EMPTY : ST_OK;
    endcase
    if (shadow_count > deepest_count) deepest_count = shadow_count;
    if (!queue_items) return;
    if (r.kind == REQ_DUMP && shadow_count != 0) begin
      for (int unsigned i = 0; i < shadow_count; i++) begin
        res.status = ST_OK;
        res.value  = shadow_list[i];
        res.index  = i[3:0];
        res.count  = shadow_count[4:0];
        res.last   = (i + 1 == shadow_count);
        awaited_results.push_back(res);
      end
    end else begin
      res.status = st;
      res.count  = shadow_count[4:0];
      res.last   = 1'b1;
      awaited_results.push_back(res);
    end
  endtask

  // Drive one item, hold it until taken, then maybe go idle for a while
  task automatic send_list_request(input list_req_t r, input bit fixed,
                                   input list_status_e st, input logic [4:0] cnt);
    list_res_t res;
    in_valid_i       <= 1'b1;
    req_type_i       <= r.kind;
    value_i          <= r.value;
    position_i       <= r.pos;
    other_position_i <= r.pos2;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    items_sent++;
    predict_list_request(r, !fixed);
    if (fixed) begin
      res        = '0;
      res.status = st;
      res.count  = cnt;
      res.last   = 1'b1;
      awaited_results.push_back(res);
    end
    @(negedge clk_i);
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid_i       <= 1'b0;
      req_type_i       <= 3'($urandom);
      value_i          <= $urandom;
      position_i       <= 5'($urandom);
      other_position_i <= 5'($urandom);
      do @(negedge clk_i); while ($urandom_range(99) < send_idle_pct);
    end
  endtask

  // Drop valid and hold off until every pending item has come back
  task automatic drain_list();
    in_valid_i <= 1'b0;
    while (awaited_results.size() != 0) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic plan_fixed(input list_req_e kind, input logic [31:0] v, input int p,
                            input int q, input list_status_e st, input int cnt);
    plan_row_t row;
    row = '0;
    row.req.kind = kind; row.req.value = v; row.req.pos = p[4:0]; row.req.pos2 = q[4:0];
    row.rep = 5'd1; row.fixed = 1'b1; row.status = st; row.count = cnt[4:0];
    plan_rows.push_back(row);
  endtask

  task automatic plan_predicted(input list_req_e kind, input logic [31:0] v, input int p,
                                input int q, input int rep);
    plan_row_t row;
    row = '0;
    row.req.kind = kind; row.req.value = v; row.req.pos = p[4:0]; row.req.pos2 = q[4:0];
    row.rep = rep[4:0];
    plan_rows.push_back(row);
  endtask

  // Random request, mostly legal for the current list depth
  function automatic list_req_t make_list_request(int unsigned grow_pct);
    list_req_t   r;
    int unsigned roll;
    r.value = $urandom;
    r.pos   = 5'($urandom);
    r.pos2  = 5'($urandom);
    roll = $urandom_range(99);
    if (roll < grow_pct) r.kind = list_req_e'($urandom_range(2));
    else if (roll < 85)  r.kind = list_req_e'(3 + $urandom_range(2));
    else if (roll < 93)  r.kind = REQ_SWAP;
    else                 r.kind = REQ_DUMP;
    if ($urandom_range(9) != 0) begin
      case (r.kind)
        REQ_INS_AT: r.pos = 5'($urandom_range(shadow_count));
        REQ_DEL_AT: r.pos = 5'((shadow_count != 0) ? $urandom_range(shadow_count - 1) : 0);
        REQ_SWAP: begin
          r.pos  = 5'((shadow_count != 0) ? $urandom_range(shadow_count - 1) : 0);
          r.pos2 = ($urandom_range(5) == 0) ? r.pos :
                   5'((shadow_count != 0) ? $urandom_range(shadow_count - 1) : 0);
        end
        default: ;
      endcase
    end
    case ($urandom_range(11))
      0: r.value = 32'h7fff_ffff;
      1: r.value = 32'h8000_0000;
      2: r.value = 32'hffff_ffff;
      3: r.value = 32'h0000_0000;
      default: ;
    endcase
    return r;
  endfunction

  // Receiver: stall at random
  initial begin
    out_ready_i = 1'b0;
    forever begin
      @(negedge clk_i);
      out_ready_i <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Compare each returned item with the oldest one pending
  always @(posedge clk_i) begin
    list_res_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      results_checked++;
      if (awaited_results.size() == 0) begin
        mismatch_count++;
        $display("%0t: unexpected item: st=%0d val=%0h idx=%0d cnt=%0d last=%0d",
                 $time, status_o, entry_value_o, entry_index_o, entry_count_o, last_o);
      end else begin
        want = awaited_results.pop_front();
        if (status_o !== want.status || entry_value_o !== want.value ||
            entry_index_o !== want.index || entry_count_o !== want.count ||
            last_o !== want.last) begin
          mismatch_count++;
          $display("%0t: mismatch: expected st=%0d val=%0h idx=%0d cnt=%0d last=%0d,",
                   $time, want.status, want.value, want.index, want.count, want.last,
                   " got st=%0d val=%0h idx=%0d cnt=%0d last=%0d",
                   status_o, entry_value_o, entry_index_o, entry_count_o, last_o);
        end
      end
    end
  end

  // Stop a hung run
  initial begin
    #(20 * 400000);
    $display("** positional_list_engine: FAILED **");
    $finish;
  end

  initial begin
    plan_row_t row;
    list_req_t r;
    rst_ni           = 1'b0;
    in_valid_i       = 1'b0;
    req_type_i       = '0;
    value_i          = '0;
    position_i       = '0;
    other_position_i = '0;
    send_idle_pct    = 0;
    recv_stall_pct   = 0;
    mismatch_count   = 0;
    items_sent       = 0;
    results_checked  = 0;
    deepest_count    = 0;
    shadow_count     = 0;
    for (int i = 0; i < LIST_DEPTH; i++) shadow_list[i] = '0;

    // Empty list: every delete, dump and swap corner, and an out-of-range insert
    plan_fixed(REQ_DUMP,      0, 0, 0, ST_EMPTY, 0);
    plan_fixed(REQ_DEL_FRONT, 0, 0, 0, ST_EMPTY, 0);
    plan_fixed(REQ_DEL_BACK,  0, 0, 0, ST_EMPTY, 0);
    plan_fixed(REQ_DEL_AT,    0, 31, 0, ST_EMPTY, 0);
    plan_fixed(REQ_SWAP,      0, 7, 7, ST_OK, 0);
    plan_fixed(REQ_SWAP,      0, 0, 1, ST_RANGE, 0);
    plan_fixed(REQ_INS_AT,    32'h1234_5678, 1, 0, ST_RANGE, 0);
    // Build a short list from value extremes, then probe range, swap, dump and delete
    plan_fixed(REQ_INS_AT,    32'h7fff_ffff, 0, 0, ST_OK, 1);
    plan_fixed(REQ_INS_BACK,  32'h8000_0000, 0, 0, ST_OK, 2);
    plan_fixed(REQ_INS_FRONT, 32'hffff_ffff, 0, 0, ST_OK, 3);
    plan_fixed(REQ_INS_AT,    32'h5555_aaaa, 31, 0, ST_RANGE, 3);
    plan_predicted(REQ_INS_AT, 32'h0000_0000, 3, 0, 1);
    plan_fixed(REQ_DEL_AT,    0, 4, 0, ST_RANGE, 4);
    plan_predicted(REQ_SWAP, 0, 0, 3, 1);
    plan_fixed(REQ_SWAP,      0, 31, 0, ST_RANGE, 4);
    plan_predicted(REQ_DUMP, 0, 0, 0, 1);
    plan_predicted(REQ_DEL_AT, 0, 1, 0, 1);
    // Fill to capacity, hit the full and range checks, then swap, dump and delete
    plan_predicted(REQ_INS_BACK, 0, 0, 0, 13);
    plan_fixed(REQ_INS_FRONT, 32'h0bad_cafe, 0, 0, ST_FULL, 16);
    plan_fixed(REQ_INS_AT,    32'h0bad_cafe, 16, 0, ST_FULL, 16);
    plan_fixed(REQ_INS_AT,    32'h0bad_cafe, 17, 0, ST_RANGE, 16);
    plan_predicted(REQ_SWAP, 0, 15, 0, 1);
    plan_predicted(REQ_DUMP, 0, 0, 0, 1);
    plan_predicted(REQ_DEL_AT, 0, 15, 0, 1);
    plan_predicted(REQ_DEL_BACK, 0, 0, 0, 1);
    plan_predicted(REQ_DEL_FRONT, 0, 0, 0, 1);

    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Walk the directed table
    foreach (plan_rows[i]) begin
      row = plan_rows[i];
      for (int k = 0; k < row.rep; k++) begin
        r = row.req;
        if (row.rep > 1) r.value = $urandom;
        send_list_request(r, row.fixed, row.status, row.count);
      end
    end
    drain_list();

    // Random phases: free flow, idle sender, stalling receiver, both
    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 82; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 82; end
        default: begin send_idle_pct = 26; recv_stall_pct = 26; end
      endcase
      for (int n = 0; n < RAND_PHASE_ITEMS; n++) begin
        r = make_list_request((phase % 2 == 0) ? 65 : 35);
        send_list_request(r, 1'b0, ST_OK, '0);
      end
      drain_list();
    end

    // Let any stray item show up
    repeat (SETTLE_CYCLES) @(posedge clk_i);

    $display("Run covered %0d requests and %0d returned items; list depth reached %0d of %0d.",
             items_sent, results_checked, deepest_count, LIST_DEPTH);
    $display("Directed corners plus four random phases with sender idling and receiver stalls.");
    if (mismatch_count == 0 && awaited_results.size() == 0) begin
      $display("** positional_list_engine: PASSED **");
    end else begin
      $display("** positional_list_engine: FAILED **");
    end
    $finish;
  end

endmodule

`default_nettype wire

@@ sim.f @@
rtl/plm_pkg.sv
rtl/plm_cell.sv
rtl/plm_ctrl.sv
rtl/positional_list_engine.sv
tb/tb_top.sv
